### rtl/core/rhim_pkg.sv
// ----------------------------------------------------------------------------
// rhim_pkg
// Shared constants, types and helpers of the HEVC-over-RTP intra region
// marker: packet bounds, NAL codes, the packet class codes and the item
// that travels from the parser to the output stage.
// ----------------------------------------------------------------------------
package rhim_pkg;

  // Packet bound; byte position and header end saturate here
  localparam int unsigned MaxPacket = 2048;
  localparam int unsigned PosW      = $clog2(MaxPacket + 1);

  // Width that holds a header end grown by the largest extension
  localparam int unsigned ExtW      = 20;

  // RTP and HEVC codes
  localparam logic [7:0] RtpHdrLen  = 8'd12;
  localparam logic [5:0] NalTypeFu  = 6'd49;
  localparam logic [5:0] NalTypeIdrW = 6'd19;
  localparam logic [5:0] NalTypeIdrN = 6'd20;
  localparam logic [5:0] NalTypeCra  = 6'd21;
  localparam int unsigned FuStartBit = 7;
  localparam logic [7:0] SkipReset  = 8'd64;

  // Payload offsets of the first IV byte and the IV length
  localparam int unsigned IvStartSingle = 2;
  localparam int unsigned IvStartFrag   = 3;
  localparam int unsigned IvLen         = 16;

  // Queue between parser and output stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CLASS_NONE      = 2'd0,
    CLASS_SINGLE    = 2'd1,
    CLASS_FRAG      = 2'd2,
    CLASS_FRAG_PEND = 2'd3
  } class_e;

  // One classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       enc;
    logic       ivv;
    logic [3:0] ivi;
    class_e     cls;
  } item_t;

  // Queue read side as seen by the output stage
  typedef struct packed {
    logic  avail;
    item_t head;
  } q_rd_t;

  function automatic logic is_intra(input logic [5:0] t);
    return (t == NalTypeIdrW) || (t == NalTypeIdrN) || (t == NalTypeCra);
  endfunction

endpackage

### rtl/core/rhim_front.sv
// ----------------------------------------------------------------------------
// rhim_front
// Packet parser: tracks the byte position and RTP header length, classifies
// the HEVC payload, flags IV and encrypted bytes, one byte per accepted cycle.
// ----------------------------------------------------------------------------
module rhim_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output rhim_pkg::item_t item_o
);
  import rhim_pkg::*;

  logic [7:0]      skip_prefix_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] hend_q, hend_d;
  logic            ext_q, ext_d;
  logic [7:0]      ext_hi_q, ext_hi_d;
  class_e          class_q, class_d;
  logic [7:0]      skip_left_q, skip_left_d;

  logic [PosW-1:0] p;
  logic [ExtW-1:0] ext_sum;
  logic            in_payload;
  logic            enc;
  logic            ivv;
  logic [3:0]      ivi;

  // Parse one byte
  always_comb begin
    pos_d       = pos_q;
    hend_d      = hend_q;
    ext_d       = ext_q;
    ext_hi_d    = ext_hi_q;
    class_d     = class_q;
    skip_left_d = skip_left_q;
    enc         = 1'b0;
    ivv         = 1'b0;
    ivi         = 4'd0;
    p           = pos_q - hend_q;
    in_payload  = 1'b0;
    ext_sum     = ExtW'(hend_q) + ExtW'(4) + (ExtW'({ext_hi_q, data_byte_i}) << 2);

    if (pos_q == '0) begin
      hend_d = PosW'(RtpHdrLen) + PosW'({data_byte_i[3:0], 2'b00});
      ext_d  = data_byte_i[4];
    end else if (ext_q) begin
      if ({1'b0, pos_q} == {1'b0, hend_q} + (PosW + 1)'(2)) begin
        ext_hi_d = data_byte_i;
      end else if ({1'b0, pos_q} == {1'b0, hend_q} + (PosW + 1)'(3)) begin
        if (ext_sum > ExtW'(MaxPacket)) begin
          hend_d = PosW'(MaxPacket);
        end else begin
          hend_d = PosW'(ext_sum);
        end
        ext_d = 1'b0;
      end
    end else if (pos_q >= hend_q && pos_q < PosW'(MaxPacket)) begin
      in_payload = 1'b1;
    end

    if (in_payload) begin
      // Classify on the NAL header and the FU header
      if (p == '0) begin
        if (is_intra(data_byte_i[6:1])) begin
          class_d = CLASS_SINGLE;
        end else if (data_byte_i[6:1] == NalTypeFu) begin
          class_d = CLASS_FRAG_PEND;
        end else begin
          class_d = CLASS_NONE;
        end
      end else if (p == PosW'(2) && class_q == CLASS_FRAG_PEND) begin
        if (is_intra(data_byte_i[5:0])) begin
          class_d = CLASS_FRAG;
          if (data_byte_i[FuStartBit]) begin
            skip_left_d = skip_prefix_q;
          end
        end else begin
          class_d = CLASS_NONE;
        end
      end

      // Mark IV and region bytes
      if (class_d == CLASS_SINGLE && p >= PosW'(IvStartSingle)) begin
        if (p < PosW'(IvStartSingle + IvLen)) begin
          ivv = 1'b1;
          ivi = 4'(p - PosW'(IvStartSingle));
        end
        if (ExtW'(p) >= ExtW'(skip_prefix_q) + ExtW'(IvStartSingle)) begin
          enc = 1'b1;
        end
      end else if (class_d == CLASS_FRAG && p >= PosW'(IvStartFrag)) begin
        if (p < PosW'(IvStartFrag + IvLen)) begin
          ivv = 1'b1;
          ivi = 4'(p - PosW'(IvStartFrag));
        end
        if (skip_left_q != '0) begin
          skip_left_d = skip_left_q - 8'd1;
        end else begin
          enc = 1'b1;
        end
      end
    end

    item_o.data = data_byte_i;
    item_o.last = last_byte_i;
    item_o.enc  = enc;
    item_o.ivv  = ivv;
    item_o.ivi  = ivi;
    item_o.cls  = (class_d == CLASS_FRAG_PEND) ? CLASS_NONE : class_d;

    // Restart per packet, saturate the position otherwise
    if (last_byte_i) begin
      pos_d    = '0;
      hend_d   = PosW'(RtpHdrLen);
      ext_d    = 1'b0;
      ext_hi_d = '0;
      class_d  = CLASS_NONE;
    end else if (pos_q < PosW'(MaxPacket)) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_prefix_q <= SkipReset;
    end else if (cfg_we_i) begin
      skip_prefix_q <= cfg_wdata_i;
    end
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hend_q      <= PosW'(RtpHdrLen);
      ext_q       <= 1'b0;
      ext_hi_q    <= '0;
      class_q     <= CLASS_NONE;
      skip_left_q <= '0;
    end else if (accept_i) begin
      pos_q       <= pos_d;
      hend_q      <= hend_d;
      ext_q       <= ext_d;
      ext_hi_q    <= ext_hi_d;
      class_q     <= class_d;
      skip_left_q <= skip_left_d;
    end
  end

endmodule

### rtl/core/rhim_queue.sv
// ----------------------------------------------------------------------------
// rhim_queue
// Short queue of classified bytes between the parser and the output stage.
// ----------------------------------------------------------------------------
module rhim_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  rhim_pkg::item_t  wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output rhim_pkg::q_rd_t  rd_o
);
  import rhim_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q;
  logic [QPtrW-1:0] rptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o     = (count_q == QCntW'(QDepth));
  assign rd_o.avail = (count_q != '0);
  assign rd_o.head  = mem_q[rptr_q];

  // Store written items
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/core/rhim_back.sv
// ----------------------------------------------------------------------------
// rhim_back
// Output stage: numbers encrypted bytes within each packet and holds the
// oldest result in an output register until it is popped.
// ----------------------------------------------------------------------------
module rhim_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rhim_pkg::q_rd_t  q_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rhim_pkg::item_t  item_o,
  output logic [10:0]      region_offset_o
);
  import rhim_pkg::*;

  logic            valid_q;
  item_t           item_q;
  logic [10:0]     off_q;
  logic [PosW-1:0] rc_q, rc_d;

  // Load when the output register is free or being drained
  assign q_pop_o = q_i.avail && (!valid_q || pop_i);

  assign empty_o         = !valid_q;
  assign item_o          = item_q;
  assign region_offset_o = off_q;

  // Count region bytes, restart at packet end
  always_comb begin
    rc_d = rc_q;
    if (q_i.head.last) begin
      rc_d = '0;
    end else if (q_i.head.enc && rc_q < PosW'(MaxPacket)) begin
      rc_d = rc_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rc_q    <= '0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      rc_q    <= rc_d;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_i.head;
      off_q  <= q_i.head.enc ? 11'(rc_q) : 11'd0;
    end
  end

endmodule

### rtl/core/rtp_hevc_iframe_region_marker.sv
// ----------------------------------------------------------------------------
// rtp_hevc_iframe_region_marker
// Marks IV bytes and the encrypted region of intra HEVC payloads in an RTP
// byte stream; every byte passes through with its marks.
//
//   Channel  Direction  Handshake        Payload
//   input    in         push / full      data_byte_i, last_byte_i
//   result   out        empty / pop      data_out_o, encrypt_mark_o,
//                                        region_offset_o, iv_valid_o,
//                                        iv_index_o, packet_class_o,
//                                        end_of_packet_o
//   config   in         cfg_we_i         cfg_wdata_i (skip prefix)
//
// One byte per cycle is accepted while full is low, and one result per cycle
// is delivered while pop is held. A result can be popped once its byte has
// passed the queue, written at the accepting edge by the combinational parser,
// and then the output register, which it enters when that register is free.
// full rises only when the queue holds four bytes behind a stalled output.
// Reset clears all control state at once; no clearing pass follows.
// ----------------------------------------------------------------------------
module rtp_hevc_iframe_region_marker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_out_o,
  output logic        encrypt_mark_o,
  output logic [10:0] region_offset_o,
  output logic        iv_valid_o,
  output logic [3:0]  iv_index_o,
  output logic [1:0]  packet_class_o,
  output logic        end_of_packet_o
);
  import rhim_pkg::*;

  logic  accept;
  item_t front_item;
  item_t out_item;
  q_rd_t q_rd;
  logic  q_pop;

  assign accept = push && !full;

  rhim_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  rhim_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (q_pop),
    .rd_o    (q_rd)
  );

  rhim_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_i             (q_rd),
    .q_pop_o         (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .item_o          (out_item),
    .region_offset_o (region_offset_o)
  );

  // Unpack the result
  assign data_out_o      = out_item.data;
  assign encrypt_mark_o  = out_item.enc;
  assign iv_valid_o      = out_item.ivv;
  assign iv_index_o      = out_item.ivi;
  assign packet_class_o  = out_item.cls;
  assign end_of_packet_o = out_item.last;

endmodule

### rtl/core/rhim_checker.sv
// ----------------------------------------------------------------------------
// rhim_checker
// Port-level checks on the result channel of the region marker, bound to
// the top level.
// ----------------------------------------------------------------------------
module rhim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  data_out_o,
  input logic        encrypt_mark_o,
  input logic [10:0] region_offset_o,
  input logic        iv_valid_o,
  input logic [3:0]  iv_index_o,
  input logic [1:0]  packet_class_o,
  input logic        end_of_packet_o
);
  import rhim_pkg::*;

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_out_o) && $stable(end_of_packet_o)))
    else $error("result changed while stalled");

  // Only intra packets carry a region
  a_enc_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && encrypt_mark_o) |->
      (packet_class_o == CLASS_SINGLE || packet_class_o == CLASS_FRAG))
    else $error("encrypted byte outside an intra packet");

  // Offset is zero off the region
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !encrypt_mark_o) |-> (region_offset_o == 11'd0))
    else $error("region offset set on an unmarked byte");

  // IV bytes only in intra packets, index zero otherwise
  a_iv_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (iv_valid_o ? (packet_class_o != CLASS_NONE) : (iv_index_o == 4'd0)))
    else $error("IV mark inconsistent with class or index");

endmodule

bind rtp_hevc_iframe_region_marker rhim_checker u_rhim_checker (.*);
